// File: sv/incremental_pid_antiwindup_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the incremental PID controller.
// Shared wrappers that give every concurrent check the same form.
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_PID_ANTIWINDUP_MACROS_SVH
`define INCREMENTAL_PID_ANTIWINDUP_MACROS_SVH

// Checked on every rising edge while reset is released.
`define IPID_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define IPID_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// File: sv/ipid_pkg.sv
// ----------------------------------------------------------------------------
// ipid_pkg
// Types, constants and helper functions of the incremental PID controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipid_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// Multiplier operand and product widths, and the accumulator width.
	localparam int MA_W  = 34;
	localparam int MB_W  = 17;
	localparam int MP_W  = MA_W + MB_W;
	localparam int ACC_W = MP_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INT_GAIN       = 3'd1,
		REG_DERIV_POLE     = 3'd2,
		REG_DERIV_GAIN     = 3'd3,
		REG_WINDUP_GAIN    = 3'd4,
		REG_INV_PLANT_GAIN = 3'd5,
		REG_MAX_DRIVE      = 3'd6
	} reg_idx_t;

	localparam logic [15:0] RST_PROP_GAIN      = 16'd4096;
	localparam logic [15:0] RST_INT_GAIN       = 16'd0;
	localparam logic [11:0] RST_DERIV_POLE     = 12'd0;
	localparam logic [15:0] RST_DERIV_GAIN     = 16'd0;
	localparam logic [15:0] RST_WINDUP_GAIN    = 16'd0;
	localparam logic [15:0] RST_INV_PLANT_GAIN = 16'd4096;
	localparam logic [15:0] RST_MAX_DRIVE      = 16'd4095;

	localparam logic [1:0] SAT_NONE = 2'd0;
	localparam logic [1:0] SAT_HIGH = 2'd1;
	localparam logic [1:0] SAT_LOW  = 2'd2;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] int_gain;
		logic [11:0] deriv_pole;
		logic [15:0] deriv_gain;
		logic [15:0] windup_gain;
		logic [15:0] inv_plant_gain;
		logic [15:0] max_drive;
	} cfg_regs_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MP,
		ST_MDP,
		ST_MDG,
		ST_DSUB,
		ST_SUM1,
		ST_SUM2,
		ST_SUM3,
		ST_USAT,
		ST_DIFF,
		ST_MV,
		ST_VSAT,
		ST_CLAMP,
		ST_MW,
		ST_ADDW,
		ST_PEND
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
		logic all_zero;
		logic all_one;
		logic signed [31:0] res;
		all_zero = ~|x[ACC_W-1:31];
		all_one  = &x[ACC_W-1:31];
		if (all_zero || all_one) begin
			res = $signed(x[31:0]);
		end else if (x[ACC_W-1]) begin
			res = 32'sh8000_0000;
		end else begin
			res = 32'sh7fff_ffff;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: sv/ipid_ifs.sv
// ----------------------------------------------------------------------------
// Channel interfaces
// Sample, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ipid_smp_if;
	logic               valid;
	logic               ready;
	logic        [15:0] setpoint;
	logic        [15:0] measurement;
	logic signed [15:0] disturbance;

	modport source (output valid, setpoint, measurement, disturbance, input ready);
	modport sink (input valid, setpoint, measurement, disturbance, output ready);
endinterface

interface ipid_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] drive;
	logic [1:0]  sat_code;

	modport source (output valid, drive, sat_code, input ready);
	modport sink (input valid, drive, sat_code, output ready);
endinterface

interface ipid_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/ipid_cfg.sv
// ----------------------------------------------------------------------------
// ipid_cfg
// Controller register bank, written through the register write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipid_cfg
	import ipid_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	ipid_cfg_if.sink         cfg,
	output cfg_regs_t        regs
);

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.prop_gain      <= RST_PROP_GAIN;
			regs_q.int_gain       <= RST_INT_GAIN;
			regs_q.deriv_pole     <= RST_DERIV_POLE;
			regs_q.deriv_gain     <= RST_DERIV_GAIN;
			regs_q.windup_gain    <= RST_WINDUP_GAIN;
			regs_q.inv_plant_gain <= RST_INV_PLANT_GAIN;
			regs_q.max_drive      <= RST_MAX_DRIVE;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_PROP_GAIN:      regs_q.prop_gain      <= cfg.data;
				REG_INT_GAIN:       regs_q.int_gain       <= cfg.data;
				REG_DERIV_POLE:     regs_q.deriv_pole     <= cfg.data[11:0];
				REG_DERIV_GAIN:     regs_q.deriv_gain     <= cfg.data;
				REG_WINDUP_GAIN:    regs_q.windup_gain    <= cfg.data;
				REG_INV_PLANT_GAIN: regs_q.inv_plant_gain <= cfg.data;
				REG_MAX_DRIVE:      regs_q.max_drive      <= cfg.data;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/ipid_mul.sv
// ----------------------------------------------------------------------------
// ipid_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipid_mul
	import ipid_pkg::*;
(
	input  logic                   clk,
	input  logic signed [MA_W-1:0] a,
	input  logic signed [MB_W-1:0] b,
	output logic signed [MP_W-1:0] prod
);

	always_ff @(posedge clk) begin
		prod <= MP_W'(a) * MP_W'(b);
	end

endmodule

`default_nettype wire

// File: sv/incremental_pid_antiwindup.sv
// ----------------------------------------------------------------------------
// incremental_pid_antiwindup: incremental PID with filtered derivative
// A sample word is taken only while the step sequencer is idle, and the
// sequencer then runs all its steps on the single shared multiplier,
// stalling in the clamp step while a result word waits to be taken.
// Reset clears the sequencer, the result valid flag and all controller history.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module incremental_pid_antiwindup
	import ipid_pkg::*;
#(
	parameter int FRAC_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	ipid_smp_if.sink    sample,
	ipid_res_if.source  result,
	ipid_cfg_if.sink    cfg
);

	cfg_regs_t regs;

	state_t state_q;
	state_t state_d;

	logic signed [MA_W-1:0]  mul_a;
	logic signed [MB_W-1:0]  mul_b;
	logic signed [MP_W-1:0]  prod;
	logic signed [ACC_W-1:0] prod_x;
	logic signed [ACC_W-1:0] prod_sh;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] top_x;
	logic signed [ACC_W-1:0] v_x;

	logic signed [16:0] err_in;
	logic signed [16:0] dmeas_in;
	logic signed [16:0] err_q;
	logic signed [16:0] dmeas_q;
	logic signed [15:0] dist_q;
	logic        [15:0] prev_meas_q;

	logic signed [31:0] p_q;
	logic signed [31:0] d_q;
	logic signed [31:0] u_q;
	logic signed [31:0] v_q;
	logic signed [31:0] windup_q;
	logic signed [31:0] prop_prev_q;
	logic signed [31:0] deriv_q;
	logic signed [31:0] pend_q;
	logic signed [31:0] ctrl_q;

	logic        res_valid_q;
	logic [15:0] drive_q;
	logic [1:0]  code_q;

	logic               smp_ready;
	logic               fire_clamp;
	logic               clamp_hi;
	logic               clamp_lo;
	logic        [15:0] drive_nxt;
	logic        [1:0]  code_nxt;
	logic signed [31:0] windup_nxt;

	ipid_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ipid_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign err_in   = $signed({1'b0, sample.setpoint}) - $signed({1'b0, sample.measurement});
	assign dmeas_in = $signed({1'b0, sample.measurement}) - $signed({1'b0, prev_meas_q});

	assign prod_x  = ACC_W'(prod);
	assign prod_sh = prod_x >>> FRAC_BITS;
	assign top_x   = ACC_W'($signed({1'b0, regs.max_drive})) <<< FRAC_BITS;
	assign v_x     = ACC_W'(v_q);

	assign clamp_hi = v_x > top_x;
	assign clamp_lo = v_q[31];

	always_comb begin
		if (clamp_hi) begin
			drive_nxt  = regs.max_drive;
			code_nxt   = SAT_HIGH;
			windup_nxt = sat32(top_x - v_x);
		end else if (clamp_lo) begin
			drive_nxt  = '0;
			code_nxt   = SAT_LOW;
			windup_nxt = sat32(-v_x);
		end else begin
			drive_nxt  = v_q[FRAC_BITS +: 16];
			code_nxt   = SAT_NONE;
			windup_nxt = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (sample.valid) begin
				state_d = ST_MP;
			end
			ST_MP:    state_d = ST_MDP;
			ST_MDP:   state_d = ST_MDG;
			ST_MDG:   state_d = ST_DSUB;
			ST_DSUB:  state_d = ST_SUM1;
			ST_SUM1:  state_d = ST_SUM2;
			ST_SUM2:  state_d = ST_SUM3;
			ST_SUM3:  state_d = ST_USAT;
			ST_USAT:  state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_MV;
			ST_MV:    state_d = ST_VSAT;
			ST_VSAT:  state_d = ST_CLAMP;
			ST_CLAMP: if (!res_valid_q || result.ready) begin
				state_d = ST_MW;
			end
			ST_MW:    state_d = ST_ADDW;
			ST_ADDW:  state_d = ST_PEND;
			ST_PEND:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		smp_ready  = 1'b0;
		fire_clamp = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		case (state_q)
			ST_IDLE: begin
				smp_ready = 1'b1;
			end
			ST_MP: begin
				mul_a = MA_W'(err_q);
				mul_b = $signed({1'b0, regs.prop_gain});
			end
			ST_MDP: begin
				mul_a = MA_W'(deriv_q);
				mul_b = MB_W'($signed({1'b0, regs.deriv_pole}));
			end
			ST_MDG: begin
				mul_a = MA_W'(dmeas_q);
				mul_b = $signed({1'b0, regs.deriv_gain});
			end
			ST_MV: begin
				mul_a = $signed(acc_q[MA_W-1:0]);
				mul_b = $signed({1'b0, regs.inv_plant_gain});
			end
			ST_CLAMP: begin
				fire_clamp = !res_valid_q || result.ready;
				mul_a      = MA_W'(err_q);
				mul_b      = $signed({1'b0, regs.int_gain});
			end
			ST_MW: begin
				mul_a = MA_W'(windup_q);
				mul_b = $signed({1'b0, regs.windup_gain});
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire_clamp) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_meas_q <= '0;
			prop_prev_q <= '0;
			deriv_q     <= '0;
			pend_q      <= '0;
			ctrl_q      <= '0;
		end else begin
			if (smp_ready && sample.valid) begin
				prev_meas_q <= sample.measurement;
			end
			if (state_q == ST_PEND) begin
				pend_q      <= sat32(acc_q);
				prop_prev_q <= p_q;
				deriv_q     <= d_q;
				ctrl_q      <= u_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (sample.valid) begin
				err_q   <= err_in;
				dmeas_q <= dmeas_in;
				dist_q  <= sample.disturbance;
			end
			ST_MDP:  p_q <= sat32(prod_x);
			ST_MDG:  acc_q <= prod_sh;
			ST_DSUB: acc_q <= acc_q - prod_x;
			ST_SUM1: begin
				d_q   <= sat32(acc_q);
				acc_q <= ACC_W'(ctrl_q) + ACC_W'(pend_q) - ACC_W'(prop_prev_q);
			end
			ST_SUM2: acc_q <= acc_q + ACC_W'(p_q) - ACC_W'(deriv_q);
			ST_SUM3: acc_q <= acc_q + ACC_W'(d_q);
			ST_USAT: u_q <= sat32(acc_q);
			ST_DIFF: acc_q <= ACC_W'(u_q) - (ACC_W'(dist_q) <<< FRAC_BITS);
			ST_VSAT: v_q <= sat32(prod_sh);
			ST_CLAMP: if (fire_clamp) begin
				windup_q <= windup_nxt;
				drive_q  <= drive_nxt;
				code_q   <= code_nxt;
			end
			ST_MW:   acc_q <= prod_x;
			ST_ADDW: acc_q <= acc_q + prod_sh;
			default: begin
			end
		endcase
	end

	assign sample.ready    = smp_ready;
	assign result.valid    = res_valid_q;
	assign result.drive    = drive_q;
	assign result.sat_code = code_q;

endmodule

`default_nettype wire

// File: sv/ipid_chk.sv
// ----------------------------------------------------------------------------
// ipid_chk
// Port-level checks of the incremental PID controller, bound to its top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "incremental_pid_antiwindup_macros.svh"

module ipid_chk
	import ipid_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        smp_valid,
	input logic        smp_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] res_drive,
	input logic [1:0]  res_sat_code
);

	`IPID_ASSERT(a_code_legal, clk, arst_n, res_valid |-> (res_sat_code == SAT_NONE || res_sat_code == SAT_HIGH || res_sat_code == SAT_LOW), "saturation code out of range")

	`IPID_ASSERT(a_low_zero, clk, arst_n, (res_valid && res_sat_code == SAT_LOW) |-> (res_drive == 16'd0), "low clamp with non-zero drive")

	`IPID_ASSERT(a_one_sample, clk, arst_n, (smp_valid && smp_ready) |=> !smp_ready, "sample taken while a sample is in work")

	`IPID_ASSERT(a_res_hold, clk, arst_n, (res_valid && !res_ready) |=> (res_valid && $stable(res_drive) && $stable(res_sat_code)), "stalled result word changed")

	`IPID_ASSERT_ALWAYS(a_rst_empty, clk, !arst_n |=> !res_valid, "result word valid out of reset")

endmodule

bind incremental_pid_antiwindup ipid_chk u_ipid_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.smp_valid    (sample.valid),
	.smp_ready    (sample.ready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_drive    (result.drive),
	.res_sat_code (result.sat_code)
);

`default_nettype wire

// File: tb/incremental_pid_antiwindup_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pid_antiwindup_test
// Self-checking bench for the incremental PID controller. A short table of
// samples, some with the drive typed in, is followed by phases of random
// samples under fresh gain sets. An in-bench copy of the control law works
// out the drive and saturation code of every accepted sample word, and the
// result words are checked in order against it. Both channels stall at random.
// ----------------------------------------------------------------------------

module incremental_pid_antiwindup_test
	import ipid_pkg::*;
();

	localparam int FRAC           = 12;
	localparam longint ONE        = longint'(1) << FRAC;
	localparam longint I32_MAX    = 64'sd2147483647;
	localparam longint I32_MIN    = -64'sd2147483648;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int RAND_PHASES    = 14;
	localparam int PHASE_SAMPLES  = 125;
	localparam int SETTLE_CYCLES  = 24;
	localparam int SQUEEZE_AT     = 300;
	localparam int SQUEEZE_CYCLES = 600;
	localparam int DIR_ROWS       = 16;
	localparam int DIR_SPLIT      = 9;
	localparam logic [2:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic [15:0] drive;
		logic [1:0]  sat_code;
	} drive_word_t;

	typedef struct packed {
		logic [15:0] sp;
		logic [15:0] meas;
		logic [15:0] dstb;
		logic        typed;
		logic [15:0] drive;
		logic [1:0]  code;
	} stim_row_t;

	// The first rows run on the reset gains, where the drive is simply the
	// control error less the disturbance. The rest run on the largest gains.
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		'{16'd0,     16'd0,     16'h0000, 1'b1, 16'd0,    SAT_NONE},
		'{16'd100,   16'd0,     16'h0000, 1'b1, 16'd100,  SAT_NONE},
		'{16'd5000,  16'd4000,  16'h01f4, 1'b1, 16'd500,  SAT_NONE},
		'{16'd65535, 16'd0,     16'h0000, 1'b1, 16'd4095, SAT_HIGH},
		'{16'd0,     16'd65535, 16'h0000, 1'b1, 16'd0,    SAT_LOW},
		'{16'd1000,  16'd0,     16'h8000, 1'b1, 16'd4095, SAT_HIGH},
		'{16'd1000,  16'd0,     16'h7fff, 1'b1, 16'd0,    SAT_LOW},
		'{16'd4095,  16'd0,     16'h0000, 1'b1, 16'd4095, SAT_NONE},
		'{16'd4096,  16'd0,     16'h0000, 1'b1, 16'd4095, SAT_HIGH},
		'{16'd65535, 16'd0,     16'h8000, 1'b0, 16'd0,    SAT_NONE},
		'{16'd0,     16'd65535, 16'h7fff, 1'b0, 16'd0,    SAT_NONE},
		'{16'd65535, 16'd0,     16'h8000, 1'b0, 16'd0,    SAT_NONE},
		'{16'd0,     16'd0,     16'h0000, 1'b0, 16'd0,    SAT_NONE},
		'{16'd32768, 16'd32767, 16'hffff, 1'b0, 16'd0,    SAT_NONE},
		'{16'd1,     16'd0,     16'h0000, 1'b0, 16'd0,    SAT_NONE},
		'{16'd0,     16'd0,     16'h0000, 1'b0, 16'd0,    SAT_NONE}
	};

	logic clk = 1'b0;
	logic arst_n;

	ipid_smp_if smp ();
	ipid_res_if res ();
	ipid_cfg_if cfg_bus ();

	incremental_pid_antiwindup dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.result (res),
		.cfg    (cfg_bus)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	cfg_regs_t   gains;
	logic [15:0] meas_hist;
	longint      prop_hist, dterm, int_carry, ctrl_sum, track_err;
	drive_word_t drive_q [$];
	int          errors = 0;
	int          results_seen = 0;

	function automatic longint clip32(input longint x);
		if (x > I32_MAX) return I32_MAX;
		if (x < I32_MIN) return I32_MIN;
		return x;
	endfunction

	function automatic drive_word_t next_drive(input logic [15:0] sp, meas, dstb);
		longint sp_l, meas_l, hist_l, dist_l, err, top, p, d, u, v;
		longint kp, ki, pole, kd, kw, kinv, maxd;
		drive_word_t r;
		sp_l = sp;
		meas_l = meas;
		hist_l = meas_hist;
		dist_l = $signed(dstb);
		kp = gains.prop_gain;
		ki = gains.int_gain;
		pole = gains.deriv_pole;
		kd = gains.deriv_gain;
		kw = gains.windup_gain;
		kinv = gains.inv_plant_gain;
		maxd = gains.max_drive;
		err = sp_l - meas_l;
		top = maxd * ONE;
		p = clip32(kp * err);
		d = clip32(((pole * dterm) >>> FRAC) - kd * (meas_l - hist_l));
		u = clip32(ctrl_sum + (p - prop_hist) + int_carry + (d - dterm));
		v = clip32(((u - dist_l * ONE) * kinv) >>> FRAC);
		if (v > top) begin
			r.drive = gains.max_drive;
			r.sat_code = SAT_HIGH;
			track_err = clip32(top - v);
		end else if (v < 0) begin
			r.drive = '0;
			r.sat_code = SAT_LOW;
			track_err = clip32(-v);
		end else begin
			r.drive = v[FRAC+15:FRAC];
			r.sat_code = SAT_NONE;
			track_err = 0;
		end
		int_carry = clip32(ki * err + ((kw * track_err) >>> FRAC));
		prop_hist = p;
		dterm = d;
		meas_hist = meas;
		ctrl_sum = u;
		return r;
	endfunction

	function automatic int pick_gap(input bit eager);
		int r;
		r = $urandom_range(0, 99);
		if (eager || r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_edge();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h8000;
			3: return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cfg_regs_t pick_gains(input int ph);
		cfg_regs_t g;
		g = '1;
		if (ph == 2) begin
			g = '0;
			g.max_drive = 16'd1;
		end else if (ph != 0 && $urandom_range(0, 99) < 30) begin
			g.prop_gain = 16'($urandom);
			g.int_gain = 16'($urandom);
			g.deriv_pole = 12'($urandom);
			g.deriv_gain = 16'($urandom);
			g.windup_gain = 16'($urandom);
			g.inv_plant_gain = 16'($urandom);
			g.max_drive = 16'($urandom);
		end else if (ph != 0) begin
			g.prop_gain = 16'($urandom_range(512, 16384));
			g.int_gain = 16'($urandom_range(0, 1024));
			g.deriv_pole = 12'($urandom_range(0, 4095));
			g.deriv_gain = 16'($urandom_range(0, 8192));
			g.windup_gain = 16'($urandom_range(0, 8192));
			g.inv_plant_gain = 16'($urandom_range(1024, 8192));
			case ($urandom_range(0, 3))
				0: g.max_drive = 16'd1;
				1: g.max_drive = 16'd4095;
				2: g.max_drive = 16'd65535;
				default: g.max_drive = 16'($urandom);
			endcase
		end
		if (ph == 1) g.max_drive = '0;
		return g;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		case (idx)
			REG_PROP_GAIN:      gains.prop_gain = data;
			REG_INT_GAIN:       gains.int_gain = data;
			REG_DERIV_POLE:     gains.deriv_pole = data[11:0];
			REG_DERIV_GAIN:     gains.deriv_gain = data;
			REG_WINDUP_GAIN:    gains.windup_gain = data;
			REG_INV_PLANT_GAIN: gains.inv_plant_gain = data;
			REG_MAX_DRIVE:      gains.max_drive = data;
			default: ;
		endcase
	endtask

	task automatic load_gains(input cfg_regs_t g, input bit poke_spare);
		logic [3:0] junk;
		junk = 4'($urandom);
		write_reg(REG_PROP_GAIN, g.prop_gain);
		write_reg(REG_INT_GAIN, g.int_gain);
		write_reg(REG_DERIV_POLE, {junk, g.deriv_pole});
		write_reg(REG_DERIV_GAIN, g.deriv_gain);
		write_reg(REG_WINDUP_GAIN, g.windup_gain);
		write_reg(REG_INV_PLANT_GAIN, g.inv_plant_gain);
		write_reg(REG_MAX_DRIVE, g.max_drive);
		if (poke_spare) write_reg(REG_SPARE, 16'($urandom));
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic offer(input logic [15:0] sp, meas, dstb, input int gap,
			input bit typed, input drive_word_t want);
		drive_word_t calc;
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.setpoint <= sp;
		smp.measurement <= meas;
		smp.disturbance <= dstb;
		do @(posedge clk); while (smp.ready !== 1'b1);
		calc = next_drive(sp, meas, dstb);
		drive_q.push_back(typed ? want : calc);
	endtask

	// The block finishes the integral step after its result word is registered, so
	// the gains are left alone for a while after the last word has come.
	task automatic wait_drained();
		smp.valid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : check_results
		drive_word_t want;
		if (res.valid === 1'b1 && res.ready === 1'b1) begin
			results_seen++;
			if (drive_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, got drive %0d sat_code %0d",
					$time, res.drive, res.sat_code);
			end else begin
				want = drive_q.pop_front();
				if (res.drive !== want.drive) begin
					errors++;
					$display("%0t: drive expected %0d, got %0d", $time, want.drive, res.drive);
				end
				if (res.sat_code !== want.sat_code) begin
					errors++;
					$display("%0t: sat_code expected %0d, got %0d",
						$time, want.sat_code, res.sat_code);
				end
			end
		end
	end

	initial begin : result_sink
		int burst, gap, r, held;
		bit squeezed;
		squeezed = 1'b0;
		res.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!squeezed && results_seen >= SQUEEZE_AT) begin
				squeezed = 1'b1;
				res.ready <= 1'b0;
				for (held = 0; held < SQUEEZE_CYCLES; held++) @(posedge clk);
			end
			burst = $urandom_range(1, 48);
			res.ready <= 1'b1;
			repeat (burst) @(posedge clk);
			r = $urandom_range(0, 99);
			gap = r < 30 ? 0 : r < 90 ? $urandom_range(1, 4) : $urandom_range(16, 80);
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		int i, ph, n, r, sp_cur, meas_cur;
		bit eager;
		logic [15:0] sp, meas, dstb;
		drive_word_t want;
		arst_n <= 1'b0;
		smp.valid <= 1'b0;
		smp.setpoint <= '0;
		smp.measurement <= '0;
		smp.disturbance <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= '0;
		cfg_bus.data <= '0;
		gains = '{RST_PROP_GAIN, RST_INT_GAIN, RST_DERIV_POLE, RST_DERIV_GAIN,
			RST_WINDUP_GAIN, RST_INV_PLANT_GAIN, RST_MAX_DRIVE};
		meas_hist = '0;
		prop_hist = 0;
		dterm = 0;
		int_carry = 0;
		ctrl_sum = 0;
		track_err = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIR_ROWS; i++) begin
			if (i == DIR_SPLIT) begin
				wait_drained();
				load_gains(pick_gains(0), 1'b1);
			end
			want.drive = DIR_TABLE[i].drive;
			want.sat_code = DIR_TABLE[i].code;
			offer(DIR_TABLE[i].sp, DIR_TABLE[i].meas, DIR_TABLE[i].dstb,
				pick_gap(1'b0), DIR_TABLE[i].typed, want);
		end

		want = '0;
		sp_cur = 2048;
		meas_cur = 0;
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			wait_drained();
			load_gains(pick_gains(ph), $urandom_range(0, 3) == 0);
			eager = (ph % 4 == 3);
			for (n = 0; n < PHASE_SAMPLES; n++) begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					if ($urandom_range(0, 31) == 0) sp_cur = $urandom_range(0, 65535);
					meas_cur = meas_cur + (sp_cur - meas_cur) / 8
						+ int'($urandom_range(0, 64)) - 32;
					if (meas_cur < 0) meas_cur = 0;
					if (meas_cur > 65535) meas_cur = 65535;
					sp = 16'(sp_cur);
					meas = 16'(meas_cur);
					dstb = 16'($urandom_range(0, 400) - 200);
				end else if (r < 85) begin
					sp = 16'($urandom);
					meas = 16'($urandom);
					dstb = 16'($urandom);
				end else begin
					sp = pick_edge();
					meas = pick_edge();
					dstb = pick_edge();
				end
				offer(sp, meas, dstb, pick_gap(eager), 1'b0, want);
			end
		end

		wait_drained();
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/ipid_pkg.sv
sv/ipid_ifs.sv
sv/ipid_cfg.sv
sv/ipid_mul.sv
sv/incremental_pid_antiwindup.sv
sv/ipid_chk.sv
tb/incremental_pid_antiwindup_test.sv
